[rtl/rps_pkg.sv]
package rps_pkg;

  typedef enum logic [2:0] {
    KIND_NONE     = 3'd0,
    KIND_WRITE    = 3'd1,
    KIND_SET      = 3'd2,
    KIND_CLEAR    = 3'd3,
    KIND_PIN_LOW  = 3'd4,
    KIND_PIN_HIGH = 3'd5
  } rps_kind_e;

  typedef enum logic [2:0] {
    ST_PENDING     = 3'd0,
    ST_OK          = 3'd1,
    ST_TIMEOUT     = 3'd2,
    ST_NO_CARD     = 3'd3,
    ST_ERROR       = 3'd4,
    ST_CHECK_ERROR = 3'd5
  } rps_status_e;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_DETECT = 2'd1,
    OP_READ   = 2'd2,
    OP_RESET  = 2'd3
  } rps_op_e;

  typedef enum logic [1:0] {
    CTL_NEXT = 2'd0,
    CTL_JUMP = 2'd1,
    CTL_END  = 2'd2
  } rps_ctl_e;

  localparam int unsigned PcW      = 5;
  localparam int unsigned RomDepth = 31;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_HAS_PIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LOW_MS   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BOOT_MS  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SOFT_MS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TRCV_MS  = 3'd4;

  localparam logic [5:0] R_NONE       = 6'h00;
  localparam logic [5:0] R_COMMAND    = 6'h01;
  localparam logic [5:0] R_COMIRQ     = 6'h04;
  localparam logic [5:0] R_FIFODATA   = 6'h09;
  localparam logic [5:0] R_FIFOLEVEL  = 6'h0A;
  localparam logic [5:0] R_BITFRAMING = 6'h0D;
  localparam logic [5:0] R_COLL       = 6'h0E;
  localparam logic [5:0] R_MODE       = 6'h11;
  localparam logic [5:0] R_TXMODE     = 6'h12;
  localparam logic [5:0] R_RXMODE     = 6'h13;
  localparam logic [5:0] R_TXCONTROL  = 6'h14;
  localparam logic [5:0] R_TXASK      = 6'h15;
  localparam logic [5:0] R_MODWIDTH   = 6'h24;
  localparam logic [5:0] R_TMODE      = 6'h2A;
  localparam logic [5:0] R_TPRESCALER = 6'h2B;
  localparam logic [5:0] R_TRELOADH   = 6'h2C;
  localparam logic [5:0] R_TRELOADL   = 6'h2D;

  localparam logic [7:0] C_IDLE       = 8'h00;
  localparam logic [7:0] C_TRANSCEIVE = 8'h0C;
  localparam logic [7:0] C_SOFTRESET  = 8'h0F;

  localparam logic [PcW-1:0] ENT_CONFIG   = 5'd0;
  localparam logic [PcW-1:0] ENT_DETECT   = 5'd10;
  localparam logic [PcW-1:0] ENT_READ     = 5'd19;
  localparam logic [PcW-1:0] ENT_TAIL     = 5'd25;
  localparam logic [PcW-1:0] ENT_PIN_LOW  = 5'd27;
  localparam logic [PcW-1:0] ENT_PIN_HIGH = 5'd28;
  localparam logic [PcW-1:0] ENT_SOFT     = 5'd29;
  localparam logic [PcW-1:0] ENT_NONE     = 5'd30;

  typedef struct packed {
    rps_ctl_e       ctl;
    logic [PcW-1:0] target;
    rps_kind_e      kind;
    logic [5:0]     addr;
    logic [7:0]     data;
  } rps_uword_t;

  typedef struct packed {
    logic           go;
    logic [PcW-1:0] entry;
    rps_status_e    status;
  } rps_cmd_t;

  function automatic rps_uword_t uw(rps_ctl_e ctl, rps_kind_e kind, logic [5:0] addr,
                                    logic [7:0] data);
    rps_uword_t w;
    w.ctl    = ctl;
    w.target = ENT_TAIL;
    w.kind   = kind;
    w.addr   = addr;
    w.data   = data;
    return w;
  endfunction

  function automatic rps_uword_t rps_rom(logic [PcW-1:0] pc);
    rps_uword_t w;
    case (pc)
      5'd0:  w = uw(CTL_NEXT, KIND_WRITE, R_TXMODE, 8'h00);
      5'd1:  w = uw(CTL_NEXT, KIND_WRITE, R_RXMODE, 8'h00);
      5'd2:  w = uw(CTL_NEXT, KIND_WRITE, R_MODWIDTH, 8'h26);
      5'd3:  w = uw(CTL_NEXT, KIND_WRITE, R_TMODE, 8'h80);
      5'd4:  w = uw(CTL_NEXT, KIND_WRITE, R_TPRESCALER, 8'hA9);
      5'd5:  w = uw(CTL_NEXT, KIND_WRITE, R_TRELOADH, 8'h03);
      5'd6:  w = uw(CTL_NEXT, KIND_WRITE, R_TRELOADL, 8'hE8);
      5'd7:  w = uw(CTL_NEXT, KIND_WRITE, R_TXASK, 8'h40);
      5'd8:  w = uw(CTL_NEXT, KIND_WRITE, R_MODE, 8'h3D);
      5'd9:  w = uw(CTL_END,  KIND_SET, R_TXCONTROL, 8'h03);
      5'd10: w = uw(CTL_NEXT, KIND_WRITE, R_TXMODE, 8'h00);
      5'd11: w = uw(CTL_NEXT, KIND_WRITE, R_RXMODE, 8'h00);
      5'd12: w = uw(CTL_NEXT, KIND_WRITE, R_MODWIDTH, 8'h26);
      5'd13: w = uw(CTL_NEXT, KIND_CLEAR, R_COLL, 8'h80);
      5'd14: w = uw(CTL_NEXT, KIND_WRITE, R_COMMAND, C_IDLE);
      5'd15: w = uw(CTL_NEXT, KIND_WRITE, R_COMIRQ, 8'h7F);
      5'd16: w = uw(CTL_NEXT, KIND_WRITE, R_FIFOLEVEL, 8'h80);
      5'd17: w = uw(CTL_NEXT, KIND_WRITE, R_FIFODATA, 8'h26);
      5'd18: w = uw(CTL_JUMP, KIND_WRITE, R_BITFRAMING, 8'h07);
      5'd19: w = uw(CTL_NEXT, KIND_WRITE, R_COMMAND, C_IDLE);
      5'd20: w = uw(CTL_NEXT, KIND_WRITE, R_COMIRQ, 8'h7F);
      5'd21: w = uw(CTL_NEXT, KIND_WRITE, R_FIFOLEVEL, 8'h80);
      5'd22: w = uw(CTL_NEXT, KIND_WRITE, R_FIFODATA, 8'h93);
      5'd23: w = uw(CTL_NEXT, KIND_WRITE, R_FIFODATA, 8'h20);
      5'd24: w = uw(CTL_JUMP, KIND_WRITE, R_BITFRAMING, 8'h00);
      5'd25: w = uw(CTL_NEXT, KIND_WRITE, R_COMMAND, C_TRANSCEIVE);
      5'd26: w = uw(CTL_END,  KIND_SET, R_BITFRAMING, 8'h80);
      5'd27: w = uw(CTL_END,  KIND_PIN_LOW, R_NONE, 8'h00);
      5'd28: w = uw(CTL_END,  KIND_PIN_HIGH, R_NONE, 8'h00);
      5'd29: w = uw(CTL_END,  KIND_WRITE, R_COMMAND, C_SOFTRESET);
      default: w = uw(CTL_END, KIND_NONE, R_NONE, 8'h00);
    endcase
    return w;
  endfunction

endpackage

[rtl/rfid_reader_poll_sequencer_unit.sv]
// Poll sequencer for a 13.56 MHz card reader. Each input beat is one
// non-blocking poll step; the block answers with one output beat per
// register access the host must perform, and the beat with tlast carries
// the step status. A step is decoded, then the microcode program walks its
// access list (up to eleven accesses; a step with none gives one beat of kind
// NONE), one control word a cycle while tready does not stall the output.
// A new step is taken once the previous program has issued its last beat.
module rfid_reader_poll_sequencer_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rps_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rps_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // now_ms, command_reg_read, irq_reg_read, fifo_level_read, card_uid_bytes, check_byte
  input  logic [95:0]                 s_axis_tdata,
  // opcode
  input  logic [1:0]                  s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // reg_addr, reg_data, status, card_uid, uid_present, zero fill
  output logic [55:0]                 m_axis_tdata,
  // access_kind
  output logic [2:0]                  m_axis_tuser,
  output logic                        m_axis_tlast
);
  import rps_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE      = 4'd0,
    S_HW_LOW    = 4'd1,
    S_HW_BOOT   = 4'd2,
    S_SOFT      = 4'd3,
    S_SOFT_WAIT = 4'd4,
    S_CONFIG    = 4'd5,
    S_READY     = 4'd6,
    S_DET_WAIT  = 4'd7,
    S_DET_CHECK = 4'd8,
    S_RD_WAIT   = 4'd9,
    S_RD_CHECK  = 4'd10
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] start_q, start_d;
  logic [31:0] uid_q, uid_d;
  logic        uv_q, uv_d;
  logic        has_pin_q;
  logic [15:0] low_ms_q, boot_ms_q, soft_ms_q, trcv_ms_q;

  logic        busy, accept;
  rps_cmd_t    cmd;
  rps_op_e     op;
  logic [31:0] now_ms, uid_in, diff;
  logic [7:0]  cmd_rd, irq_rd, fifo_rd, chk, xsum;
  logic [15:0] limit;
  logic        timed_out, irq_hit;

  assign op      = rps_op_e'(s_axis_tuser);
  assign now_ms  = s_axis_tdata[31:0];
  assign cmd_rd  = s_axis_tdata[39:32];
  assign irq_rd  = s_axis_tdata[47:40];
  assign fifo_rd = s_axis_tdata[55:48];
  assign uid_in  = s_axis_tdata[87:56];
  assign chk     = s_axis_tdata[95:88];

  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && !busy;

  always_comb begin
    case (state_q)
      S_HW_LOW:    limit = low_ms_q;
      S_HW_BOOT:   limit = boot_ms_q;
      S_SOFT_WAIT: limit = soft_ms_q;
      default:     limit = trcv_ms_q;
    endcase
  end

  assign diff      = now_ms - start_q;
  assign timed_out = diff >= {16'd0, limit};
  assign irq_hit   = |irq_rd[5:4];
  assign xsum      = uid_in[7:0] ^ uid_in[15:8] ^ uid_in[23:16] ^ uid_in[31:24];

  always_comb begin
    state_d    = state_q;
    start_d    = start_q;
    uid_d      = uid_q;
    uv_d       = uv_q;
    cmd.go     = accept;
    cmd.entry  = ENT_NONE;
    cmd.status = ST_PENDING;
    case (op)
      OP_INIT: begin
        case (state_q)
          S_IDLE: begin
            if (has_pin_q) begin
              cmd.entry = ENT_PIN_LOW;
              start_d   = now_ms;
              state_d   = S_HW_LOW;
            end else begin
              state_d = S_SOFT;
            end
          end
          S_HW_LOW: begin
            if (timed_out) begin
              cmd.entry = ENT_PIN_HIGH;
              start_d   = now_ms;
              state_d   = S_HW_BOOT;
            end
          end
          S_HW_BOOT: begin
            if (timed_out) begin
              state_d = S_SOFT;
            end
          end
          S_SOFT: begin
            cmd.entry = ENT_SOFT;
            start_d   = now_ms;
            state_d   = S_SOFT_WAIT;
          end
          S_SOFT_WAIT: begin
            if (!cmd_rd[4] || timed_out) begin
              state_d = S_CONFIG;
            end
          end
          S_CONFIG: begin
            cmd.entry  = ENT_CONFIG;
            cmd.status = ST_OK;
            state_d    = S_READY;
          end
          default: cmd.status = ST_ERROR;
        endcase
      end
      OP_DETECT: begin
        case (state_q)
          S_IDLE, S_READY: begin
            cmd.entry = ENT_DETECT;
            start_d   = now_ms;
            state_d   = S_DET_WAIT;
          end
          S_DET_WAIT: begin
            if (irq_hit) begin
              state_d = S_DET_CHECK;
            end else if (timed_out) begin
              state_d    = S_READY;
              cmd.status = ST_TIMEOUT;
            end
          end
          S_DET_CHECK: begin
            state_d    = S_READY;
            cmd.status = (fifo_rd == 8'd2) ? ST_OK : ST_NO_CARD;
          end
          default: begin
            state_d    = S_READY;
            cmd.status = ST_ERROR;
          end
        endcase
      end
      OP_READ: begin
        case (state_q)
          S_READY: begin
            cmd.entry = ENT_READ;
            start_d   = now_ms;
            state_d   = S_RD_WAIT;
          end
          S_RD_WAIT: begin
            if (irq_hit) begin
              state_d = S_RD_CHECK;
            end else if (timed_out) begin
              state_d    = S_READY;
              cmd.status = ST_TIMEOUT;
            end
          end
          S_RD_CHECK: begin
            state_d = S_READY;
            if (fifo_rd < 8'd5) begin
              cmd.status = ST_ERROR;
            end else if (xsum != chk) begin
              cmd.status = ST_CHECK_ERROR;
            end else begin
              cmd.status = ST_OK;
              uid_d      = uid_in;
              uv_d       = 1'b1;
            end
          end
          default: begin
            state_d    = S_READY;
            cmd.status = ST_ERROR;
          end
        endcase
      end
      default: begin
        state_d    = S_IDLE;
        cmd.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      start_q   <= '0;
      uid_q     <= '0;
      uv_q      <= 1'b0;
      has_pin_q <= 1'b1;
      low_ms_q  <= 16'd10;
      boot_ms_q <= 16'd50;
      soft_ms_q <= 16'd50;
      trcv_ms_q <= 16'd36;
    end else begin
      if (accept) begin
        state_q <= state_d;
        start_q <= start_d;
        uid_q   <= uid_d;
        uv_q    <= uv_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HAS_PIN: has_pin_q <= cfg_data_i[0];
          CFG_LOW_MS:  low_ms_q  <= cfg_data_i;
          CFG_BOOT_MS: boot_ms_q <= cfg_data_i;
          CFG_SOFT_MS: soft_ms_q <= cfg_data_i;
          CFG_TRCV_MS: trcv_ms_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  rps_useq u_useq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .uid_i         (uid_q),
    .uid_valid_i   (uv_q),
    .busy_o        (busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  a_uid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(uv_q) |-> uv_q)
    else $error("Stored card identity was dropped.");

  a_uid_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(uid_q) |-> $past(accept) && $past(state_q) == S_RD_CHECK)
    else $error("Card identity changed outside a read check.");

  a_start_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(start_q) |-> $past(accept))
    else $error("Start time moved without a step.");

endmodule

[rtl/rps_useq.sv]
module rps_useq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rps_pkg::rps_cmd_t cmd_i,
  input  logic [31:0]       uid_i,
  input  logic              uid_valid_i,
  output logic              busy_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // reg_addr, reg_data, status, card_uid, uid_present, zero fill
  output logic [55:0]       m_axis_tdata,
  // access_kind
  output logic [2:0]        m_axis_tuser,
  output logic              m_axis_tlast
);
  import rps_pkg::*;

  logic           busy_q, busy_d;
  logic [PcW-1:0] pc_q, pc_d;
  rps_status_e    st_q, st_d;
  logic           valid_q, valid_d;
  rps_kind_e      kind_q, kind_d;
  logic [5:0]     addr_q, addr_d;
  logic [7:0]     data_q, data_d;
  rps_status_e    ost_q, ost_d;
  logic [31:0]    uid_q, uid_d;
  logic           uv_q, uv_d;
  logic           last_q, last_d;
  rps_uword_t     word;
  logic           load;

  assign word = rps_rom(pc_q);
  assign load = busy_q && (!valid_q || m_axis_tready);

  always_comb begin
    busy_d  = busy_q;
    pc_d    = pc_q;
    st_d    = st_q;
    valid_d = valid_q;
    kind_d  = kind_q;
    addr_d  = addr_q;
    data_d  = data_q;
    ost_d   = ost_q;
    uid_d   = uid_q;
    uv_d    = uv_q;
    last_d  = last_q;
    if (valid_q && m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (cmd_i.go) begin
      busy_d = 1'b1;
      pc_d   = cmd_i.entry;
      st_d   = cmd_i.status;
    end else if (load) begin
      valid_d = 1'b1;
      kind_d  = word.kind;
      addr_d  = word.addr;
      data_d  = word.data;
      uid_d   = uid_i;
      uv_d    = uid_valid_i;
      last_d  = (word.ctl == CTL_END);
      ost_d   = (word.ctl == CTL_END) ? st_q : ST_PENDING;
      case (word.ctl)
        CTL_END:  busy_d = 1'b0;
        CTL_JUMP: pc_d = word.target;
        default:  pc_d = pc_q + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      pc_q    <= ENT_NONE;
      st_q    <= ST_PENDING;
      valid_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      pc_q    <= pc_d;
      st_q    <= st_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    data_q <= data_d;
    ost_q  <= ost_d;
    uid_q  <= uid_d;
    uv_q   <= uv_d;
    last_q <= last_d;
  end

  assign busy_o        = busy_q;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tdata  = {6'd0, uv_q, uid_q, ost_q, data_q, addr_q};

  a_go_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.go |-> !busy_q)
    else $error("Step started while a program is running.");

  a_pc_in_rom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pc_q < PcW'(RomDepth))
    else $error("Program counter left the control store.");

  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !last_q |-> ost_q == ST_PENDING)
    else $error("Status shown on a beat that is not the last of its step.");

  a_load_after_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.go |=> busy_q && !$stable(busy_q))
    else $error("Program did not start after a step was taken.");

endmodule
